@@ src/pt64_pkg.sv @@
package pt64_pkg;

    localparam int unsigned DataW = 64;
    localparam int unsigned NumBases = 7;
    localparam int unsigned NumSmall = 24;

    typedef enum logic [3:0] {
        t_idle_st,
        t_trial_st,
        t_round_st,
        t_pow_mul_st,
        t_pow_sq_st,
        t_chk_st,
        t_sq_st,
        t_done_st
    } t_state;

    typedef struct packed {
        logic            start;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
    } t_mul_req;

    function automatic logic [6:0] small_prime(input logic [4:0] idx);
        logic [6:0] p;
        unique case (idx)
            5'd0: p = 7'd3;    5'd1: p = 7'd5;    5'd2: p = 7'd7;    5'd3: p = 7'd11;
            5'd4: p = 7'd13;   5'd5: p = 7'd17;   5'd6: p = 7'd19;   5'd7: p = 7'd23;
            5'd8: p = 7'd29;   5'd9: p = 7'd31;   5'd10: p = 7'd37;  5'd11: p = 7'd41;
            5'd12: p = 7'd43;  5'd13: p = 7'd47;  5'd14: p = 7'd53;  5'd15: p = 7'd59;
            5'd16: p = 7'd61;  5'd17: p = 7'd67;  5'd18: p = 7'd71;  5'd19: p = 7'd73;
            5'd20: p = 7'd79;  5'd21: p = 7'd83;  5'd22: p = 7'd89;  5'd23: p = 7'd97;
            default: p = 7'd3;
        endcase
        return p;
    endfunction

    // floor(2^22 / p) for each small prime, same order as small_prime.
    function automatic logic [20:0] small_recip(input logic [4:0] idx);
        logic [20:0] r;
        unique case (idx)
            5'd0: r = 21'd1398101;  5'd1: r = 21'd838860;   5'd2: r = 21'd599186;
            5'd3: r = 21'd381300;   5'd4: r = 21'd322638;   5'd5: r = 21'd246723;
            5'd6: r = 21'd220752;   5'd7: r = 21'd182361;   5'd8: r = 21'd144631;
            5'd9: r = 21'd135300;   5'd10: r = 21'd113359;  5'd11: r = 21'd102300;
            5'd12: r = 21'd97541;   5'd13: r = 21'd89240;   5'd14: r = 21'd79137;
            5'd15: r = 21'd71089;   5'd16: r = 21'd68759;   5'd17: r = 21'd62601;
            5'd18: r = 21'd59074;   5'd19: r = 21'd57456;   5'd20: r = 21'd53092;
            5'd21: r = 21'd50533;   5'd22: r = 21'd47127;   5'd23: r = 21'd43240;
            default: r = 21'd1398101;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] witness(input logic [2:0] idx);
        logic [31:0] w;
        unique case (idx)
            3'd0: w = 32'd2;
            3'd1: w = 32'd325;
            3'd2: w = 32'd9375;
            3'd3: w = 32'd28178;
            3'd4: w = 32'd450775;
            3'd5: w = 32'd9780504;
            3'd6: w = 32'd1795265022;
            default: w = 32'd2;
        endcase
        return w;
    endfunction

endpackage

@@ src/pt64_modmul.sv @@
module pt64_modmul #(
    parameter int unsigned W = pt64_pkg::DataW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pt64_pkg::t_mul_req  i_req,
    input  logic [W-1:0]        i_mod,
    output logic                o_done,
    output logic [W-1:0]        o_prod
);
    // Shift-and-add, MSB first: acc = 2*acc (+ a) mod m, one bit a cycle.
    localparam int unsigned CntW = $clog2(W + 1);

    logic [W-1:0]    r_acc, n_acc;
    logic [W-1:0]    r_a;
    logic [W-1:0]    r_b;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [W:0]      dbl, dbl_red, sum;

    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_mod}) ? dbl - {1'b0, i_mod} : dbl;
        sum     = dbl_red + {1'b0, r_a};
        if (r_b[W-1]) begin
            n_acc = (sum >= {1'b0, i_mod}) ? W'(sum - {1'b0, i_mod}) : sum[W-1:0];
        end else begin
            n_acc = dbl_red[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

@@ src/pt64_trial.sv @@
module pt64_trial #(
    parameter int unsigned W = pt64_pkg::DataW
) (
    input  logic         i_clk,
    input  logic         i_start,
    input  logic [W-1:0] i_n,
    input  logic [6:0]   i_p,
    input  logic [20:0]  i_recip,
    output logic         o_done,
    output logic         o_zero
);
    // Remainder by one small prime, a byte a cycle: estimate the quotient
    // with floor(2^22 / p), then correct with one compare and subtract.
    localparam int unsigned Chunks = W / 8;
    localparam int unsigned CntW = $clog2(Chunks + 1);

    logic [W-1:0]    r_n;
    logic [6:0]      r_rem;
    logic [CntW-1:0] r_cnt;
    logic [14:0]     x;
    logic [35:0]     q_est;
    logic [20:0]     qp;
    logic [14:0]     rem;
    logic [6:0]      n_rem;

    assign x     = {r_rem, r_n[W-1 -: 8]};
    assign q_est = {21'd0, x} * {15'd0, i_recip};
    assign qp    = {7'd0, q_est[35:22]} * {14'd0, i_p};
    assign rem   = x - qp[14:0];
    assign n_rem = (rem >= {8'd0, i_p}) ? 7'(rem - {8'd0, i_p}) : rem[6:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_rem <= '0;
            r_cnt <= CntW'(Chunks);
        end else if (r_cnt != '0) begin
            r_n   <= {r_n[W-9:0], 8'd0};
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = (r_cnt == '0) && !i_start;
    assign o_zero = (r_rem == '0);
endmodule

@@ src/primality_test_64_core.sv @@
// Sequence: trial division by each of 24 small primes, then per base up to
// 128 modular products on one shared bit-serial modular multiplier; 0, 1, 2
// and even candidates are decided directly without trial division.
// Throughput: one candidate at a time; the next is taken the cycle after the
// result beat leaves, and the result register holds while i_stall is high.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
module primality_test_64_core #(
    parameter int unsigned W = pt64_pkg::DataW
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [W-1:0] i_candidate,
    output logic         o_valid,
    input  logic         i_stall,
    output logic         o_prime_flag
);
    localparam int unsigned EW = $clog2(W + 1);

    pt64_pkg::t_state r_state, n_state;
    logic [W-1:0] r_n;
    logic [W-1:0] r_x, r_b, r_e;
    logic [W-1:0] n_x, n_b, n_e;
    logic [W-1:0] nm1;
    logic [4:0]   r_pi, n_pi;
    logic [2:0]   r_bi, n_bi;
    logic [EW-1:0] r_tw, n_tw;   // squarings still allowed
    logic [EW-1:0] r_s, n_s;     // trailing zeros of n-1
    logic         r_res, n_res;
    logic         r_ov, n_ov;
    logic         r_tstart, n_tstart;
    logic         mul_done, t_done, t_zero;
    logic [W-1:0] prod;
    logic [W-1:0] base_red;
    pt64_pkg::t_mul_req req;
    logic [EW-1:0] tz;
    logic         tz_hit;
    logic [6:0]   cur_p;
    logic [20:0]  cur_recip;

    assign nm1       = r_n - 1'b1;
    assign cur_p     = pt64_pkg::small_prime(r_pi);
    assign cur_recip = pt64_pkg::small_recip(r_pi);
    // Bases fit 31 bits; n may still be below the base, so reduce it first.
    assign base_red = {{(W-32){1'b0}}, pt64_pkg::witness(r_bi)};

    // Lowest set bit of n-1 (n odd and above 97, so bit 0 is clear).
    always_comb begin
        tz     = '0;
        tz_hit = 1'b0;
        for (int i = 1; i < W; i++) begin
            if (!tz_hit && nm1[i]) begin
                tz     = EW'(i);
                tz_hit = 1'b1;
            end
        end
    end

    pt64_trial #(.W(W)) u_trial (
        .i_clk  (i_clk),
        .i_start(r_tstart),
        .i_n    (r_n),
        .i_p    (cur_p),
        .i_recip(cur_recip),
        .o_done (t_done),
        .o_zero (t_zero)
    );

    pt64_modmul #(.W(W)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .i_mod  (r_n),
        .o_done (mul_done),
        .o_prod (prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pt64_pkg::t_idle_st;
            r_ov     <= 1'b0;
            r_tstart <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ov     <= n_ov;
            r_tstart <= n_tstart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pt64_pkg::t_idle_st && i_valid) r_n <= i_candidate;
        r_x   <= n_x;
        r_b   <= n_b;
        r_e   <= n_e;
        r_pi  <= n_pi;
        r_bi  <= n_bi;
        r_tw  <= n_tw;
        r_s   <= n_s;
        r_res <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_x = r_x; n_b = r_b; n_e = r_e;
        n_pi = r_pi; n_bi = r_bi; n_tw = r_tw; n_s = r_s;
        n_res = r_res;
        n_ov = r_ov;
        n_tstart = 1'b0;
        req = '{start: 1'b0, a: r_x, b: r_b};
        unique case (r_state)
            pt64_pkg::t_idle_st: begin
                if (i_valid) begin
                    n_pi = '0;
                    n_bi = '0;
                    if (i_candidate < W'(2)) begin
                        n_res = 1'b0; n_state = pt64_pkg::t_done_st;
                    end else if (i_candidate == W'(2)) begin
                        n_res = 1'b1; n_state = pt64_pkg::t_done_st;
                    end else if (!i_candidate[0]) begin
                        n_res = 1'b0; n_state = pt64_pkg::t_done_st;
                    end else begin
                        n_tstart = 1'b1; n_state = pt64_pkg::t_trial_st;
                    end
                end
            end
            pt64_pkg::t_trial_st: begin
                if (t_done) begin
                    if (r_n == {{(W-7){1'b0}}, cur_p}) begin
                        n_res = 1'b1; n_state = pt64_pkg::t_done_st;
                    end else if (t_zero) begin
                        n_res = 1'b0; n_state = pt64_pkg::t_done_st;
                    end else if (r_pi == 5'(pt64_pkg::NumSmall - 1)) begin
                        n_s = tz; n_state = pt64_pkg::t_round_st;
                    end else begin
                        n_pi = r_pi + 1'b1; n_tstart = 1'b1;
                    end
                end
            end
            pt64_pkg::t_round_st: begin
                n_x = W'(1);
                n_b = base_red;
                n_e = nm1 >> r_s;
                n_tw = r_s - 1'b1;
                // Reduce base: 1 * base mod n, fed MSB first from the base.
                req = '{start: 1'b1, a: W'(1), b: base_red};
                n_state = pt64_pkg::t_chk_st;
                n_ov = 1'b1;
            end
            pt64_pkg::t_pow_mul_st: begin
                if (mul_done) begin
                    if (r_ov) begin
                        n_x = prod;
                    end else begin
                        n_b = prod;
                        n_e = r_e >> 1;
                    end
                    n_ov = 1'b0;
                    if (r_ov) begin
                        req = '{start: 1'b1, a: r_b, b: r_b};
                    end else if (r_e[1]) begin
                        // next bit set: multiply first
                        req = '{start: 1'b1, a: r_x, b: prod};
                        n_ov = 1'b1;
                    end else if ((r_e >> 1) != '0) begin
                        req = '{start: 1'b1, a: prod, b: prod};
                    end else begin
                        n_state = pt64_pkg::t_sq_st;
                    end
                    if (!r_ov && (r_e >> 1) == '0) n_state = pt64_pkg::t_sq_st;
                end
            end
            pt64_pkg::t_chk_st: begin
                // base mod n ready
                if (mul_done) begin
                    if (prod == '0) begin
                        n_state = pt64_pkg::t_pow_sq_st; // round passes
                    end else begin
                        n_b = prod;
                        n_state = pt64_pkg::t_pow_mul_st;
                        if (r_e[0]) begin
                            req = '{start: 1'b1, a: r_x, b: prod};
                            n_ov = 1'b1;
                        end else begin
                            req = '{start: 1'b1, a: prod, b: prod};
                            n_ov = 1'b0;
                        end
                    end
                end
            end
            pt64_pkg::t_sq_st: begin
                // r_x holds base^d (first entry) or a squared value
                if (r_x == W'(1) && r_tw == r_s - 1'b1 || r_x == nm1) begin
                    n_state = pt64_pkg::t_pow_sq_st;
                end else if (r_tw == '0) begin
                    n_res = 1'b0; n_state = pt64_pkg::t_done_st;
                end else begin
                    req = '{start: 1'b1, a: r_x, b: r_x};
                    n_ov = 1'b1;
                    n_tw = r_tw - 1'b1;
                    n_state = pt64_pkg::t_chk_st;
                    n_e = '0;
                    n_x = r_x;
                end
            end
            pt64_pkg::t_pow_sq_st: begin
                if (r_bi == 3'(pt64_pkg::NumBases - 1)) begin
                    n_res = 1'b1; n_state = pt64_pkg::t_done_st;
                end else begin
                    n_bi = r_bi + 1'b1; n_state = pt64_pkg::t_round_st;
                end
            end
            pt64_pkg::t_done_st: begin
                if (!i_stall) n_state = pt64_pkg::t_idle_st;
            end
            default: n_state = pt64_pkg::t_idle_st;
        endcase
        // squaring phase reuses chk state with r_e == 0 sentinel via r_ov
        if (r_state == pt64_pkg::t_chk_st && mul_done && r_e == '0 && r_ov
            && r_tw != r_s - 1'b1) begin
            n_x = prod;
            req = '{start: 1'b0, a: r_x, b: r_b};
            n_state = pt64_pkg::t_sq_st;
            n_ov = 1'b0;
        end
    end

    assign o_stall      = (r_state != pt64_pkg::t_idle_st);
    assign o_valid      = (r_state == pt64_pkg::t_done_st);
    assign o_prime_flag = r_res;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("result repeated");
    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_prime_flag))
        else $error("stalled result changed");
endmodule
